// ===== hdl/spag_pkg.sv =====
// Sliding-piece attack generator package: op codes, line masks, byte reversal.
// No dependencies; used by spag_line, spag_rank and sliding_piece_attack_generator.
package spag_pkg;

  localparam int unsigned BOARD_W = 64;
  localparam int unsigned SQ_W    = 6;
  localparam int unsigned OP_W    = 3;

  localparam logic [OP_W-1:0] OP_FILE   = 3'd0;
  localparam logic [OP_W-1:0] OP_RANK   = 3'd1;
  localparam logic [OP_W-1:0] OP_DIAG   = 3'd2;
  localparam logic [OP_W-1:0] OP_ANTI   = 3'd3;
  localparam logic [OP_W-1:0] OP_BISHOP = 3'd4;
  localparam logic [OP_W-1:0] OP_ROOK   = 3'd5;
  localparam logic [OP_W-1:0] OP_QUEEN  = 3'd6;
  localparam logic [OP_W-1:0] OP_NONE   = 3'd7;

  localparam logic [BOARD_W-1:0] FILE_A_LINE = 64'h0101_0101_0101_0101;
  localparam logic [BOARD_W-1:0] DIAG_LINE   = 64'h8040_2010_0804_0201;
  localparam logic [BOARD_W-1:0] ANTI_LINE   = 64'h0102_0408_1020_4080;
  localparam logic [7:0]         INNER_RANK_MASK = 8'o176;
  localparam logic [SQ_W-1:0]    FLIP_RANKS  = 6'd56;

  typedef logic [BOARD_W-1:0] board_t;
  typedef logic [SQ_W-1:0]    sq_index_t;
  typedef logic [OP_W-1:0]    op_t;

  function automatic board_t byte_reverse(input board_t x);
    board_t r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = x[8*(7-i) +: 8];
    end
    return r;
  endfunction

  function automatic board_t file_mask(input sq_index_t sq);
    board_t m;
    m = (FILE_A_LINE << sq[2:0]) & ~(board_t'(1) << sq);
    return m;
  endfunction

  function automatic board_t diag_mask(input sq_index_t sq);
    logic [2:0] r;
    logic [2:0] f;
    board_t     m;
    r = sq[5:3];
    f = sq[2:0];
    if (r >= f) begin
      m = DIAG_LINE << {r - f, 3'b000};
    end else begin
      m = DIAG_LINE >> {f - r, 3'b000};
    end
    return m & ~(board_t'(1) << sq);
  endfunction

  function automatic board_t anti_mask(input sq_index_t sq);
    logic [3:0] sum;
    logic [3:0] amt;
    board_t     m;
    sum = {1'b0, sq[5:3]} + {1'b0, sq[2:0]};
    if (sum >= 4'd7) begin
      amt = sum - 4'd7;
      m = ANTI_LINE << {amt[2:0], 3'b000};
    end else begin
      amt = 4'd7 - sum;
      m = ANTI_LINE >> {amt[2:0], 3'b000};
    end
    return m & ~(board_t'(1) << sq);
  endfunction

endpackage

// ===== hdl/spag_line.sv =====
// Hyperbola-quintessence attacks along one masked line (file or diagonal).
// Depends on spag_pkg.
module spag_line (
  input  spag_pkg::board_t    occ,
  input  spag_pkg::sq_index_t sq,
  input  spag_pkg::board_t    mask,
  output spag_pkg::board_t    att
);

  spag_pkg::board_t s;
  spag_pkg::board_t rs;
  spag_pkg::board_t o;
  spag_pkg::board_t fwd;
  spag_pkg::board_t rev;

  always_comb begin
    s   = spag_pkg::board_t'(1) << sq;
    rs  = spag_pkg::board_t'(1) << (sq ^ spag_pkg::FLIP_RANKS);
    o   = occ & mask;
    fwd = o - (s << 1);
    rev = spag_pkg::byte_reverse(spag_pkg::byte_reverse(o) - (rs << 1));
    att = (fwd ^ rev) & mask;
  end

endmodule

// ===== hdl/spag_rank.sv =====
// Rank attacks from the six inner occupancy bits of the slider's rank.
// Depends on spag_pkg.
module spag_rank (
  input  spag_pkg::board_t    occ,
  input  spag_pkg::sq_index_t sq,
  output spag_pkg::board_t    att
);

  function automatic logic [7:0] rank_ray(input logic [7:0] inner, input logic [2:0] f);
    logic [7:0] a;
    logic       lstop;
    logic       rstop;
    logic [2:0] idx;
    a     = '0;
    lstop = 1'b0;
    rstop = 1'b0;
    for (int k = 1; k < 8; k++) begin
      if (3'(k) <= f && !lstop) begin
        idx    = f - 3'(k);
        a[idx] = 1'b1;
        if (inner[idx]) lstop = 1'b1;
      end
      if (3'(k) <= 3'd7 - f && !rstop) begin
        idx    = f + 3'(k);
        a[idx] = 1'b1;
        if (inner[idx]) rstop = 1'b1;
      end
    end
    return a;
  endfunction

  logic [7:0] inner;
  logic [7:0] ray;

  always_comb begin
    inner = occ[{sq[5:3], 3'b000} +: 8] & spag_pkg::INNER_RANK_MASK;
    ray   = rank_ray(inner, sq[2:0]);
    att   = spag_pkg::board_t'(ray) << {sq[5:3], 3'b000};
  end

endmodule

// ===== hdl/sliding_piece_attack_generator.sv =====
// Top level of the sliding-piece attack generator: input register, line units, result register.
// Depends on spag_pkg, spag_line and spag_rank.
//
// Usage:
//   Input channel: drive in_occupancy, in_square and in_op with start high; the item is
//   taken at the clock edge where start is high and busy is low. busy is always low, so
//   an item can be issued every cycle.
//   in_op: 0 file, 1 rank, 2 diagonal, 3 anti-diagonal, 4 bishop, 5 rook, 6 queen,
//   7 gives an empty set.
//   Result channel: out_attacks is valid for exactly one cycle while out_valid is high.
//   Each item passes through the input register and then the result register.
//   Throughput: 1 item per cycle; each spag_line unit does two 64-bit subtracts between the
//   input and result registers.
//   Reset (rst_n low, synchronous) drops any item in flight; out_valid goes low.
//   The receiver cannot stall: each result must be taken in the cycle it is shown.
module sliding_piece_attack_generator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  spag_pkg::board_t    in_occupancy,
  input  spag_pkg::sq_index_t in_square,
  input  spag_pkg::op_t       in_op,
  output logic                out_valid,
  output spag_pkg::board_t    out_attacks
);

  logic                vld_r;
  spag_pkg::board_t    occ_r;
  spag_pkg::sq_index_t sq_r;
  spag_pkg::op_t       op_r;
  logic                out_valid_r;
  spag_pkg::board_t    attacks_r;
  spag_pkg::board_t    attacks_nxt;

  spag_pkg::board_t  file_att;
  spag_pkg::board_t  diag_att;
  spag_pkg::board_t  anti_att;
  spag_pkg::board_t  rank_att;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= start && !busy;
      out_valid_r <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      occ_r <= in_occupancy;
      sq_r  <= in_square;
      op_r  <= in_op;
    end
    if (vld_r) begin
      attacks_r <= attacks_nxt;
    end
  end

  spag_line u_file (
    .occ  (occ_r),
    .sq   (sq_r),
    .mask (spag_pkg::file_mask(sq_r)),
    .att  (file_att)
  );

  spag_line u_diag (
    .occ  (occ_r),
    .sq   (sq_r),
    .mask (spag_pkg::diag_mask(sq_r)),
    .att  (diag_att)
  );

  spag_line u_anti (
    .occ  (occ_r),
    .sq   (sq_r),
    .mask (spag_pkg::anti_mask(sq_r)),
    .att  (anti_att)
  );

  spag_rank u_rank (
    .occ (occ_r),
    .sq  (sq_r),
    .att (rank_att)
  );

  always_comb begin
    unique case (op_r)
      spag_pkg::OP_FILE:   attacks_nxt = file_att;
      spag_pkg::OP_RANK:   attacks_nxt = rank_att;
      spag_pkg::OP_DIAG:   attacks_nxt = diag_att;
      spag_pkg::OP_ANTI:   attacks_nxt = anti_att;
      spag_pkg::OP_BISHOP: attacks_nxt = diag_att | anti_att;
      spag_pkg::OP_ROOK:   attacks_nxt = file_att | rank_att;
      spag_pkg::OP_QUEEN:  attacks_nxt = diag_att | anti_att | file_att | rank_att;
      default:             attacks_nxt = '0;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_attacks = attacks_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##2 out_valid)
    else $error("item accepted without a result two cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !start |-> ##2 !out_valid)
    else $error("result strobe without an accepted item");

  a_own_square: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |=> !out_attacks[$past(sq_r)])
    else $error("slider square reported as attacked");

  a_unused_op: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && op_r == spag_pkg::OP_NONE) |=> (out_attacks == '0))
    else $error("unused selector gave a nonempty set");
`endif

endmodule

// ===== test/attack_checker.sv =====
// Checker for the sliding-piece attack generator: watches both channels, predicts
// each item's attack set and compares it with the result. Depends on spag_pkg.
module attack_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  spag_pkg::board_t    in_occupancy,
  input  spag_pkg::sq_index_t in_square,
  input  spag_pkg::op_t       in_op,
  input  logic                out_valid,
  input  spag_pkg::board_t    out_attacks,
  output int                  error_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  spag_pkg::board_t expected_attacks[$];

  function automatic spag_pkg::board_t flip_ranks(spag_pkg::board_t x);
    spag_pkg::board_t r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = x[8*(7-i) +: 8];
    end
    return r;
  endfunction

  function automatic spag_pkg::board_t shift_ranks(spag_pkg::board_t line, int d);
    if (d >= 0) begin
      return line << (8 * d);
    end
    return line >> (8 * (-d));
  endfunction

  // hyperbola quintessence on one masked line
  function automatic spag_pkg::board_t hq_line(spag_pkg::board_t occ,
                                               spag_pkg::sq_index_t sq,
                                               spag_pkg::board_t mask);
    spag_pkg::board_t s;
    spag_pkg::board_t rs;
    spag_pkg::board_t o;
    spag_pkg::board_t fwd;
    spag_pkg::board_t rev;
    s   = spag_pkg::board_t'(1) << sq;
    rs  = spag_pkg::board_t'(1) << (sq ^ spag_pkg::FLIP_RANKS);
    o   = occ & mask;
    fwd = o - (s << 1);
    rev = flip_ranks(flip_ranks(o) - (rs << 1));
    return (fwd ^ rev) & mask;
  endfunction

  function automatic spag_pkg::board_t rank_ray(spag_pkg::board_t occ,
                                                spag_pkg::sq_index_t sq);
    logic [7:0] inner;
    logic [7:0] span;
    int         f;
    int         base;
    base  = 8 * int'(sq[5:3]);
    f     = int'(sq[2:0]);
    inner = occ[base +: 8] & spag_pkg::INNER_RANK_MASK;
    span  = '0;
    for (int i = f - 1; i >= 0; i--) begin
      span[i] = 1'b1;
      if (inner[i]) break;
    end
    for (int i = f + 1; i < 8; i++) begin
      span[i] = 1'b1;
      if (inner[i]) break;
    end
    return spag_pkg::board_t'(span) << base;
  endfunction

  function automatic spag_pkg::board_t predict_attacks(spag_pkg::board_t occ,
                                                       spag_pkg::sq_index_t sq,
                                                       spag_pkg::op_t op);
    spag_pkg::board_t not_s;
    spag_pkg::board_t file_a;
    spag_pkg::board_t rank_a;
    spag_pkg::board_t diag_a;
    spag_pkg::board_t anti_a;
    int               r;
    int               f;
    r      = int'(sq[5:3]);
    f      = int'(sq[2:0]);
    not_s  = ~(spag_pkg::board_t'(1) << sq);
    file_a = hq_line(occ, sq, (spag_pkg::FILE_A_LINE << f) & not_s);
    diag_a = hq_line(occ, sq, shift_ranks(spag_pkg::DIAG_LINE, r - f) & not_s);
    anti_a = hq_line(occ, sq, shift_ranks(spag_pkg::ANTI_LINE, r + f - 7) & not_s);
    rank_a = rank_ray(occ, sq);
    unique case (op)
      spag_pkg::OP_FILE:   return file_a;
      spag_pkg::OP_RANK:   return rank_a;
      spag_pkg::OP_DIAG:   return diag_a;
      spag_pkg::OP_ANTI:   return anti_a;
      spag_pkg::OP_BISHOP: return diag_a | anti_a;
      spag_pkg::OP_ROOK:   return file_a | rank_a;
      spag_pkg::OP_QUEEN:  return diag_a | anti_a | file_a | rank_a;
      default:             return '0;
    endcase
  endfunction

  always @(posedge clk) begin
    spag_pkg::board_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_attacks.size() == 0) begin
          $error("attacks: result with no item outstanding, actual %h", out_attacks);
          error_count <= error_count + 1;
        end else begin
          want = expected_attacks.pop_front();
          if (out_attacks !== want) begin
            $error("attacks mismatch: expected %h actual %h", want, out_attacks);
            error_count <= error_count + 1;
          end
        end
      end
      if (start && !busy) begin
        expected_attacks.push_back(predict_attacks(in_occupancy, in_square, in_op));
      end
      pending <= expected_attacks.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// Top of the sliding-piece attack generator testbench: clock, reset, directed and
// random items, verdict. Depends on spag_pkg, attack_checker and the block itself.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  spag_pkg::board_t    in_occupancy;
  spag_pkg::sq_index_t in_square;
  spag_pkg::op_t       in_op;
  logic                out_valid;
  spag_pkg::board_t    out_attacks;
  int                  error_count;
  int                  pending;

  sliding_piece_attack_generator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_occupancy (in_occupancy),
    .in_square    (in_square),
    .in_op        (in_op),
    .out_valid    (out_valid),
    .out_attacks  (out_attacks)
  );

  attack_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_occupancy (in_occupancy),
    .in_square    (in_square),
    .in_op        (in_op),
    .out_valid    (out_valid),
    .out_attacks  (out_attacks),
    .error_count  (error_count),
    .pending      (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic send_item(spag_pkg::board_t occ, spag_pkg::sq_index_t sq,
                           spag_pkg::op_t op);
    start        <= 1'b1;
    in_occupancy <= occ;
    in_square    <= sq;
    in_op        <= op;
    do @(posedge clk); while (busy);
  endtask

  task automatic maybe_idle(bit allow);
    if (allow && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic spag_pkg::board_t random_board();
    spag_pkg::board_t b;
    b = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: b = b & {$urandom, $urandom} & {$urandom, $urandom};
      1: b = b | {$urandom, $urandom};
      default: ;
    endcase
    return b;
  endfunction

  initial begin
    spag_pkg::board_t    occ;
    spag_pkg::sq_index_t sq;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_occupancy <= '0;
    in_square    <= '0;
    in_op        <= spag_pkg::OP_FILE;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty and full boards, every op, corners
    for (int op = 0; op < 8; op++) begin
      send_item('0, 6'd0, spag_pkg::op_t'(op));
    end
    for (int op = 0; op < 8; op++) begin
      send_item('1, 6'd63, spag_pkg::op_t'(op));
    end
    // slider square occupied or not
    occ = 64'h00a4_1200_0830_4410;
    send_item(occ | (spag_pkg::board_t'(1) << 27), 6'd27, spag_pkg::OP_QUEEN);
    send_item(occ & ~(spag_pkg::board_t'(1) << 27), 6'd27, spag_pkg::OP_QUEEN);
    // rank edge squares never block; then a corner bishop and alternating-file queens
    send_item(64'h0000_0000_0000_0081, 6'd3, spag_pkg::OP_RANK);
    send_item('1, 6'd56, spag_pkg::OP_ROOK);
    send_item('0, 6'd7, spag_pkg::OP_BISHOP);
    send_item(64'haaaa_aaaa_aaaa_aaaa, 6'd36, spag_pkg::OP_QUEEN);
    send_item(64'h5555_5555_5555_5555, 6'd36, spag_pkg::OP_QUEEN);

    for (int n = 0; n < 1030; n++) begin
      maybe_idle(n < 400 || n >= 650);
      occ = random_board();
      sq  = spag_pkg::sq_index_t'($urandom_range(0, 63));
      case ($urandom_range(0, 2))
        0: occ = occ | (spag_pkg::board_t'(1) << sq);
        1: occ = occ & ~(spag_pkg::board_t'(1) << sq);
        default: ;
      endcase
      send_item(occ, sq, spag_pkg::op_t'($urandom_range(0, 7)));
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #100000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
